@@ rtl/tcce_pkg.sv @@
// Shared types, geometry constants and character codes for the text console engine.
package tcce_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = ROWS * COLUMNS;

   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CELL_W = 16;

   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_TAB       = 8'd9;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] ATTR_RESET   = 8'h07;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SCROLL
   } state_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] char_code;
      logic [4:0] read_row;
      logic [6:0] read_column;
   } req_type;

   typedef struct packed {
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_column;
      logic [15:0] cell_value;
      logic        scrolled;
   } rsp_type;

   function automatic logic [CELL_W-1:0] make_cell(input logic [7:0] ch, input logic [7:0] attr);
      return {attr, ch};
   endfunction

endpackage

@@ rtl/tcce_cell_ram.sv @@
// Generic single-write, single-read memory with registered read data.
module tcce_cell_ram #(
   parameter int DEPTH = 2000,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/tcce_addr_unit.sv @@
// Shared address unit: maps a screen row through the scroll origin and forms the cell address.
module tcce_addr_unit (
   input  logic [tcce_pkg::ROW_W-1:0]  row,
   input  logic [tcce_pkg::COL_W-1:0]  column,
   input  logic [tcce_pkg::ROW_W-1:0]  top_row,
   output logic [tcce_pkg::ADDR_W-1:0] addr
);

   logic [tcce_pkg::ROW_W:0]   row_sum;
   logic [tcce_pkg::ROW_W:0]   row_wrap;
   logic [tcce_pkg::ROW_W-1:0] phys_row;

   always_comb begin
      row_sum = {1'b0, row} + {1'b0, top_row};
      if (row_sum >= (tcce_pkg::ROW_W+1)'(tcce_pkg::ROWS)) begin
         row_wrap = row_sum - (tcce_pkg::ROW_W+1)'(tcce_pkg::ROWS);
      end else begin
         row_wrap = row_sum;
      end
      phys_row = row_wrap[tcce_pkg::ROW_W-1:0];
      addr = tcce_pkg::ADDR_W'(phys_row) * tcce_pkg::ADDR_W'(tcce_pkg::COLUMNS)
           + tcce_pkg::ADDR_W'(column);
   end

endmodule

@@ rtl/text_console_cursor_engine.sv @@
// Top level of the text console engine: sequencer, cursor, scroll origin and cell store.
//
// Usage: drive req_data and raise start while busy is low; the beat is taken at that edge.
// busy stays high until the result has been formed. Each request yields exactly one
// response beat: rsp_valid is high for one cycle with rsp_data, and must be taken then.
// csr_wr_en/csr_wr_data load the color attribute used for printed and blanked cells.
//
// After the accepting edge a write is done in the EXEC state, an in-range read passes EXEC
// and then READ for the registered memory read, and a write that scrolls passes EXEC and
// then SCROLL while the shared address unit blanks the new bottom row, one cell
// per cycle through the single memory write port. Scrolling moves no rows: a scroll
// origin register rotates the row mapping. A new request is taken only once busy is low
// again, so requests never overlap; start may be raised in the response cycle.
//
// Reset: synchronous, active high. After reset the block sweeps the whole store to the
// blank cell 0x0720, one cell per cycle (ROWS*COLUMNS = 2000 cells) with busy high;
// configuration writes are taken during the sweep. The cursor and attribute reset to
// row 0, column 0 and attribute 0x07. The receiver cannot stall the response.
module text_console_cursor_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  tcce_pkg::req_type  req_data,
   output logic               rsp_valid,
   output tcce_pkg::rsp_type  rsp_data,
   input  logic               csr_wr_en,
   input  logic [7:0]         csr_wr_data
);

   tcce_pkg::state_type state_ff, state_in;

   tcce_pkg::req_type req_ff, req_in;
   tcce_pkg::rsp_type res_ff, res_in;

   logic [tcce_pkg::ROW_W-1:0] cur_row_ff, cur_row_in;
   logic [tcce_pkg::COL_W-1:0] cur_col_ff, cur_col_in;
   logic [tcce_pkg::ROW_W-1:0] top_ff, top_in;
   logic [tcce_pkg::ROW_W-1:0] sweep_row_ff, sweep_row_in;
   logic [tcce_pkg::COL_W-1:0] sweep_col_ff, sweep_col_in;
   logic [7:0]                 attr_ff, attr_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic [tcce_pkg::ROW_W-1:0]  unit_row;
   logic [tcce_pkg::COL_W-1:0]  unit_col;
   logic [tcce_pkg::ADDR_W-1:0] unit_addr;

   logic                        mem_wr_en;
   logic [tcce_pkg::CELL_W-1:0] mem_wr_data;
   logic                        mem_rd_en;
   logic [tcce_pkg::CELL_W-1:0] mem_rd_data;

   logic read_in_range;
   logic need_scroll;
   logic sweep_last;
   logic scroll_last;

   tcce_addr_unit u_addr (
      .row     (unit_row),
      .column  (unit_col),
      .top_row (top_ff),
      .addr    (unit_addr)
   );

   tcce_cell_ram #(
      .DEPTH (tcce_pkg::CELLS),
      .WIDTH (tcce_pkg::CELL_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (unit_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (unit_addr),
      .rd_data (mem_rd_data)
   );

   assign read_in_range = (req_ff.read_row < tcce_pkg::ROW_W'(tcce_pkg::ROWS))
                       && (req_ff.read_column < tcce_pkg::COL_W'(tcce_pkg::COLUMNS));
   assign sweep_last  = (sweep_row_ff == tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1))
                     && (sweep_col_ff == tcce_pkg::COL_W'(tcce_pkg::COLUMNS - 1));
   assign scroll_last = (sweep_col_ff == tcce_pkg::COL_W'(tcce_pkg::COLUMNS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcce_pkg::ST_CLEAR: begin
            if (sweep_last) begin
               state_in = tcce_pkg::ST_IDLE;
            end
         end
         tcce_pkg::ST_IDLE: begin
            if (start) begin
               state_in = tcce_pkg::ST_EXEC;
            end
         end
         tcce_pkg::ST_EXEC: begin
            priority if (req_ff.mode == tcce_pkg::MODE_READ && read_in_range) begin
               state_in = tcce_pkg::ST_READ;
            end else if (need_scroll) begin
               state_in = tcce_pkg::ST_SCROLL;
            end else begin
               state_in = tcce_pkg::ST_IDLE;
            end
         end
         tcce_pkg::ST_READ: begin
            state_in = tcce_pkg::ST_IDLE;
         end
         tcce_pkg::ST_SCROLL: begin
            if (scroll_last) begin
               state_in = tcce_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcce_pkg::ST_CLEAR;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      logic [tcce_pkg::COL_W:0] col_inc;
      logic [tcce_pkg::COL_W:0] col_tab;
      logic [tcce_pkg::ROW_W:0] row_inc;
      logic                     wrap;
      logic [tcce_pkg::CELL_W-1:0] blank;

      col_inc = {1'b0, cur_col_ff} + (tcce_pkg::COL_W+1)'(1);
      col_tab = ({1'b0, cur_col_ff} + (tcce_pkg::COL_W+1)'(4)) & ~(tcce_pkg::COL_W+1)'(3);
      row_inc = {1'b0, cur_row_ff} + (tcce_pkg::ROW_W+1)'(1);
      blank   = tcce_pkg::make_cell(tcce_pkg::CH_SPACE, attr_ff);
      wrap    = 1'b0;

      req_in       = req_ff;
      res_in       = res_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      top_in       = top_ff;
      sweep_row_in = sweep_row_ff;
      sweep_col_in = sweep_col_ff;
      attr_in      = csr_wr_en ? csr_wr_data : attr_ff;
      rsp_valid_in = 1'b0;
      need_scroll  = 1'b0;
      unit_row     = cur_row_ff;
      unit_col     = cur_col_ff;
      mem_wr_en    = 1'b0;
      mem_wr_data  = blank;
      mem_rd_en    = 1'b0;

      unique case (state_ff)
         tcce_pkg::ST_CLEAR: begin
            unit_row    = sweep_row_ff;
            unit_col    = sweep_col_ff;
            mem_wr_en   = 1'b1;
            mem_wr_data = tcce_pkg::make_cell(tcce_pkg::CH_SPACE, tcce_pkg::ATTR_RESET);
            if (scroll_last) begin
               sweep_col_in = '0;
               sweep_row_in = sweep_row_ff + tcce_pkg::ROW_W'(1);
            end else begin
               sweep_col_in = sweep_col_ff + tcce_pkg::COL_W'(1);
            end
         end
         tcce_pkg::ST_IDLE: begin
            if (start) begin
               req_in = req_data;
            end
         end
         tcce_pkg::ST_EXEC: begin
            res_in.cell_value = '0;
            res_in.scrolled   = 1'b0;
            if (req_ff.mode == tcce_pkg::MODE_READ) begin
               unit_row  = req_ff.read_row;
               unit_col  = req_ff.read_column;
               mem_rd_en = read_in_range;
            end else begin
               unique case (req_ff.char_code)
                  tcce_pkg::CH_NEWLINE: begin
                     wrap = 1'b1;
                  end
                  tcce_pkg::CH_BACKSPACE: begin
                     if (cur_col_ff != '0) begin
                        unit_col          = cur_col_ff - tcce_pkg::COL_W'(1);
                        cur_col_in        = cur_col_ff - tcce_pkg::COL_W'(1);
                        mem_wr_en         = 1'b1;
                        mem_wr_data       = blank;
                        res_in.cell_value = blank;
                     end
                  end
                  tcce_pkg::CH_TAB: begin
                     cur_col_in = col_tab[tcce_pkg::COL_W-1:0];
                     wrap = (col_tab >= (tcce_pkg::COL_W+1)'(tcce_pkg::COLUMNS));
                  end
                  default: begin
                     mem_wr_en         = 1'b1;
                     mem_wr_data       = tcce_pkg::make_cell(req_ff.char_code, attr_ff);
                     res_in.cell_value = tcce_pkg::make_cell(req_ff.char_code, attr_ff);
                     cur_col_in        = col_inc[tcce_pkg::COL_W-1:0];
                     wrap = (col_inc >= (tcce_pkg::COL_W+1)'(tcce_pkg::COLUMNS));
                  end
               endcase
               if (wrap) begin
                  cur_col_in = '0;
                  if (row_inc >= (tcce_pkg::ROW_W+1)'(tcce_pkg::ROWS)) begin
                     need_scroll     = 1'b1;
                     cur_row_in      = tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1);
                     res_in.scrolled = 1'b1;
                     sweep_col_in    = '0;
                     if (top_ff == tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1)) begin
                        top_in = '0;
                     end else begin
                        top_in = top_ff + tcce_pkg::ROW_W'(1);
                     end
                  end else begin
                     cur_row_in = row_inc[tcce_pkg::ROW_W-1:0];
                  end
               end
            end
            res_in.cursor_row    = cur_row_in;
            res_in.cursor_column = cur_col_in;
            rsp_valid_in = !(req_ff.mode == tcce_pkg::MODE_READ && read_in_range)
                        && !need_scroll;
         end
         tcce_pkg::ST_READ: begin
            res_in.cell_value = mem_rd_data;
            rsp_valid_in      = 1'b1;
         end
         tcce_pkg::ST_SCROLL: begin
            unit_row     = tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1);
            unit_col     = sweep_col_ff;
            mem_wr_en    = 1'b1;
            mem_wr_data  = blank;
            sweep_col_in = sweep_col_ff + tcce_pkg::COL_W'(1);
            rsp_valid_in = scroll_last;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcce_pkg::ST_CLEAR;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         top_ff       <= '0;
         sweep_row_ff <= '0;
         sweep_col_ff <= '0;
         attr_ff      <= tcce_pkg::ATTR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         top_ff       <= top_in;
         sweep_row_ff <= sweep_row_in;
         sweep_col_ff <= sweep_col_in;
         attr_ff      <= attr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      res_ff <= res_in;
   end

   assign busy      = (state_ff != tcce_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = res_ff;

endmodule

@@ tb/text_console_cursor_engine_tb.sv @@
// Self-checking testbench for the text console engine: cursor moves, scrolls and cell reads.
module text_console_cursor_engine_tb;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int MAX_REPORTS = 10;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   tcce_pkg::req_type req_data;
   logic              rsp_valid;
   tcce_pkg::rsp_type rsp_data;
   logic              csr_wr_en;
   logic [7:0]        csr_wr_data;

   logic [tcce_pkg::CELL_W-1:0] screen_image [tcce_pkg::ROWS][tcce_pkg::COLUMNS];
   int unsigned                 cursor_row_now;
   int unsigned                 cursor_col_now;
   logic [7:0]                  attr_now;
   tcce_pkg::rsp_type           predicted_replies [$];
   tcce_pkg::rsp_type           oldest_reply;

   int  fail_count = 0;
   int  cycle_count = 0;
   int  beats_sent = 0;
   int  reads_sent = 0;
   int  scrolls_seen = 0;
   int  replies_checked = 0;
   int  attr_writes = 0;
   bit  no_gap = 1'b0;

   text_console_cursor_engine DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
                  predicted_replies.size());
         $display("text_console_cursor_engine_tb: FAIL");
         $finish;
      end
   end

   task automatic clear_console();
      attr_now       = tcce_pkg::ATTR_RESET;
      cursor_row_now = 0;
      cursor_col_now = 0;
      for (int r = 0; r < tcce_pkg::ROWS; r++)
         for (int c = 0; c < tcce_pkg::COLUMNS; c++)
            screen_image[r][c] = {tcce_pkg::ATTR_RESET, tcce_pkg::CH_SPACE};
   endtask

   function automatic bit line_feed();
      cursor_col_now = 0;
      cursor_row_now++;
      if (cursor_row_now >= tcce_pkg::ROWS) begin
         for (int r = 0; r < tcce_pkg::ROWS - 1; r++)
            for (int c = 0; c < tcce_pkg::COLUMNS; c++)
               screen_image[r][c] = screen_image[r + 1][c];
         for (int c = 0; c < tcce_pkg::COLUMNS; c++)
            screen_image[tcce_pkg::ROWS - 1][c] = {attr_now, tcce_pkg::CH_SPACE};
         cursor_row_now = tcce_pkg::ROWS - 1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic tcce_pkg::rsp_type console_step(input tcce_pkg::req_type beat);
      tcce_pkg::rsp_type           reply;
      logic [tcce_pkg::CELL_W-1:0] word;
      bit                          did_scroll;
      word       = '0;
      did_scroll = 1'b0;
      if (beat.mode == tcce_pkg::MODE_READ) begin
         if (int'(beat.read_row) < tcce_pkg::ROWS
             && int'(beat.read_column) < tcce_pkg::COLUMNS)
            word = screen_image[beat.read_row][beat.read_column];
      end else if (beat.char_code == tcce_pkg::CH_NEWLINE) begin
         did_scroll = line_feed();
      end else if (beat.char_code == tcce_pkg::CH_BACKSPACE) begin
         if (cursor_col_now > 0) begin
            cursor_col_now--;
            word = {attr_now, tcce_pkg::CH_SPACE};
            screen_image[cursor_row_now][cursor_col_now] = word;
         end
      end else if (beat.char_code == tcce_pkg::CH_TAB) begin
         cursor_col_now = (cursor_col_now + 4) & ~32'd3;
         if (cursor_col_now >= tcce_pkg::COLUMNS)
            did_scroll = line_feed();
      end else begin
         word = {attr_now, beat.char_code};
         screen_image[cursor_row_now][cursor_col_now] = word;
         cursor_col_now++;
         if (cursor_col_now >= tcce_pkg::COLUMNS)
            did_scroll = line_feed();
      end
      reply.cursor_row    = cursor_row_now[4:0];
      reply.cursor_column = cursor_col_now[6:0];
      reply.cell_value    = word;
      reply.scrolled      = did_scroll;
      return reply;
   endfunction

   task automatic flag_error(input string what);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_console();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (predicted_replies.size() == 0) begin
               flag_error($sformatf("unexpected reply %p", rsp_data));
            end else begin
               oldest_reply = predicted_replies.pop_front();
               replies_checked++;
               if (rsp_data.cursor_row !== oldest_reply.cursor_row)
                  flag_error($sformatf("cursor_row expected %0d got %0d",
                                       oldest_reply.cursor_row, rsp_data.cursor_row));
               if (rsp_data.cursor_column !== oldest_reply.cursor_column)
                  flag_error($sformatf("cursor_column expected %0d got %0d",
                                       oldest_reply.cursor_column, rsp_data.cursor_column));
               if (rsp_data.cell_value !== oldest_reply.cell_value)
                  flag_error($sformatf("cell_value expected %h got %h",
                                       oldest_reply.cell_value, rsp_data.cell_value));
               if (rsp_data.scrolled !== oldest_reply.scrolled)
                  flag_error($sformatf("scrolled expected %0b got %0b",
                                       oldest_reply.scrolled, rsp_data.scrolled));
            end
         end
         if (csr_wr_en)
            attr_now = csr_wr_data;
         if (start && busy === 1'b0) begin
            predicted_replies.push_back(console_step(req_data));
            if (predicted_replies[$].scrolled)
               scrolls_seen++;
         end
      end
   end

   task automatic send_beat(input tcce_pkg::req_type beat);
      int gap;
      gap = no_gap ? 0 : int'($urandom_range(0, 5));
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (busy !== 1'b0);
      beats_sent++;
      if (beat.mode == tcce_pkg::MODE_READ)
         reads_sent++;
   endtask

   task automatic drain_replies();
      @(negedge clock);
      start <= 1'b0;
      while (predicted_replies.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_attr(input logic [7:0] value);
      drain_replies();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      attr_writes++;
   endtask

   function automatic logic [7:0] printable_code();
      logic [7:0] code;
      do code = 8'($urandom_range(0, 255));
      while (code == tcce_pkg::CH_NEWLINE || code == tcce_pkg::CH_BACKSPACE
             || code == tcce_pkg::CH_TAB);
      return code;
   endfunction

   task automatic put_char(input logic [7:0] code);
      tcce_pkg::req_type beat;
      beat.mode        = tcce_pkg::MODE_WRITE;
      beat.char_code   = code;
      beat.read_row    = 5'($urandom_range(0, 31));
      beat.read_column = 7'($urandom_range(0, 127));
      send_beat(beat);
   endtask

   task automatic read_cell(input logic [4:0] row, input logic [6:0] col);
      tcce_pkg::req_type beat;
      beat.mode        = tcce_pkg::MODE_READ;
      beat.char_code   = 8'($urandom_range(0, 255));
      beat.read_row    = row;
      beat.read_column = col;
      send_beat(beat);
   endtask

   task automatic test_reset_state();
      read_cell(5'd0, 7'd0);
      read_cell(5'(tcce_pkg::ROWS - 1), 7'(tcce_pkg::COLUMNS - 1));
      read_cell(5'd12, 7'd40);
      read_cell(5'(tcce_pkg::ROWS), 7'd0);
      read_cell(5'd0, 7'(tcce_pkg::COLUMNS));
      read_cell(5'd31, 7'd127);
   endtask

   task automatic test_control_codes();
      write_attr(8'hFF);
      put_char(tcce_pkg::CH_BACKSPACE);
      put_char(8'h00);
      put_char(8'hFF);
      put_char(tcce_pkg::CH_BACKSPACE);
      put_char(tcce_pkg::CH_TAB);
      put_char(tcce_pkg::CH_TAB);
      put_char(tcce_pkg::CH_NEWLINE);
      read_cell(5'd0, 7'd0);
      read_cell(5'd0, 7'd1);
      read_cell(5'd1, 7'd0);
   endtask

   task automatic test_scroll();
      write_attr(8'($urandom_range(1, 254)));
      for (int i = 0; i < 30; i++) begin
         repeat ($urandom_range(0, 2)) put_char(printable_code());
         put_char(tcce_pkg::CH_NEWLINE);
      end
      repeat (4) read_cell(5'(tcce_pkg::ROWS - 1),
                           7'($urandom_range(0, tcce_pkg::COLUMNS - 1)));
      repeat (4) read_cell(5'(tcce_pkg::ROWS - 2),
                           7'($urandom_range(0, tcce_pkg::COLUMNS - 1)));
   endtask

   task automatic test_line_end();
      int tabs;
      write_attr(8'h00);
      for (int pass = 0; pass < 3; pass++) begin
         put_char(tcce_pkg::CH_NEWLINE);
         tabs = $urandom_range(10, 19);
         repeat (tabs) put_char(tcce_pkg::CH_TAB);
         repeat (tcce_pkg::COLUMNS - 4 * tabs) put_char(printable_code());
         read_cell(5'(tcce_pkg::ROWS - 2), 7'(tcce_pkg::COLUMNS - 1));
      end
      for (int pass = 0; pass < 4; pass++) begin
         repeat (tcce_pkg::COLUMNS / 4 - 1) put_char(tcce_pkg::CH_TAB);
         repeat ($urandom_range(0, 3)) put_char(printable_code());
         put_char(tcce_pkg::CH_TAB);
      end
   endtask

   task automatic test_random_mix();
      logic [7:0] phase_attr [4];
      int         pick;
      phase_attr[0] = 8'h00;
      phase_attr[1] = 8'hFF;
      phase_attr[2] = 8'($urandom_range(0, 255));
      phase_attr[3] = 8'($urandom_range(0, 255));
      for (int phase = 0; phase < 4; phase++) begin
         write_attr(phase_attr[phase]);
         for (int i = 0; i < 280; i++) begin
            if (i % 40 == 0)
               no_gap = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 10)
               put_char(tcce_pkg::CH_NEWLINE);
            else if (pick < 18)
               put_char(tcce_pkg::CH_BACKSPACE);
            else if (pick < 28)
               put_char(tcce_pkg::CH_TAB);
            else if (pick < 70)
               put_char(8'($urandom_range(0, 255)));
            else if (pick < 92)
               read_cell(5'($urandom_range(0, tcce_pkg::ROWS - 1)),
                         7'($urandom_range(0, tcce_pkg::COLUMNS - 1)));
            else
               read_cell(5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
         end
      end
      no_gap = 1'b0;
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_control_codes();
      test_scroll();
      test_line_end();
      test_random_mix();
      write_attr(tcce_pkg::ATTR_RESET);

      drain_replies();
      repeat (8) @(negedge clock);
      $display("covered %0d beats (%0d reads), %0d replies checked, %0d scrolls",
               beats_sent, reads_sent, replies_checked, scrolls_seen);
      $display("%0d attribute writes, %0d errors", attr_writes, fail_count);
      if (fail_count == 0)
         $display("text_console_cursor_engine_tb: PASS");
      else
         $display("text_console_cursor_engine_tb: FAIL");
      $finish;
   end

endmodule

@@ files.f @@
rtl/tcce_pkg.sv
rtl/tcce_cell_ram.sv
rtl/tcce_addr_unit.sv
rtl/text_console_cursor_engine.sv
tb/text_console_cursor_engine_tb.sv
